>>> hdl/cbm_pkg.sv
`default_nettype none
package cbm_pkg;
   localparam int PIX_W = 8;
   localparam int CH_MAX = 3;
   localparam int TIME_W = 16;
   localparam int ENTRY_W = 4 * CH_MAX * PIX_W + 2 * TIME_W;

   localparam logic [1:0] OP_LEARN = 2'd0;
   localparam logic [1:0] OP_CLASSIFY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [2:0] CSR_LEARN_BOUNDS = 3'd0;
   localparam logic [2:0] CSR_MIN_MOD_C0 = 3'd1;
   localparam logic [2:0] CSR_MIN_MOD_C1 = 3'd2;
   localparam logic [2:0] CSR_MIN_MOD_C2 = 3'd3;
   localparam logic [2:0] CSR_MAX_MOD_C0 = 3'd4;
   localparam logic [2:0] CSR_MAX_MOD_C1 = 3'd5;
   localparam logic [2:0] CSR_MAX_MOD_C2 = 3'd6;
   localparam logic [2:0] CSR_STALE_LIMIT = 3'd7;

   typedef struct packed {
      logic [CH_MAX-1:0][PIX_W-1:0] learn_hi;
      logic [CH_MAX-1:0][PIX_W-1:0] learn_lo;
      logic [CH_MAX-1:0][PIX_W-1:0] box_max;
      logic [CH_MAX-1:0][PIX_W-1:0] box_min;
      logic [TIME_W-1:0] last_time;
      logic [TIME_W-1:0] stale;
   } entry_type;
endpackage
`default_nettype wire

>>> hdl/codebook_background_model_core.sv
`default_nettype none
// Codebook background model. Every request (learn, classify, clear) passes
// through the states IDLE, in which it is accepted, READ, in which the pixel's
// codebook row and its entry count are read from the two registered-read memories,
// EVAL, which evaluates all entries of the row side by side, and RESP, which presents
// the result while the row is written back. busy is high in READ, EVAL and RESP, so a
// new request is taken only once the previous one has finished. The response strobe
// rsp_valid is high for exactly one cycle and the result cannot be stalled.
// Codebook rows are not cleared at reset; only the per-pixel entry count is,
// by a sweep over all NUM_PIXELS pixel indices after reset during which busy stays high
// (CSR writes are taken).
module codebook_background_model_core #(
   parameter int NUM_PIXELS = 4096,
   parameter int MAX_ENTRIES = 8,
   parameter int CHANNELS = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [11:0] req_pixel_index,
   input  wire logic [7:0]  req_channel_0,
   input  wire logic [7:0]  req_channel_1,
   input  wire logic [7:0]  req_channel_2,
   input  wire logic [15:0] req_frame_time,
   output logic             rsp_valid,
   output logic [3:0]       rsp_entry_index,
   output logic             rsp_foreground,
   output logic [3:0]       rsp_cleared_count,
   output logic             rsp_table_full,
   output logic [3:0]       rsp_entry_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import cbm_pkg::*;

   localparam int PA_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int ROW_W = MAX_ENTRIES * ENTRY_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_EVAL = 3'd3;
   localparam logic [2:0] ST_RESP = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [PA_W-1:0] sweep_ff, sweep_in;

   logic [23:0] bounds_ff;
   logic [CH_MAX-1:0][8:0] min_mod_ff, max_mod_ff;
   logic [15:0] limit_ff;

   logic [1:0] op_ff;
   logic [PA_W-1:0] pix_ff;
   logic in_range_ff;
   logic [CH_MAX-1:0][7:0] p_ff;
   logic [15:0] t_ff;

   entry_type row_mem [NUM_PIXELS][MAX_ENTRIES];
   logic [CNT_W-1:0] cnt_mem [NUM_PIXELS];
   entry_type [MAX_ENTRIES-1:0] row_q;
   logic [CNT_W-1:0] cnt_q;

   entry_type [MAX_ENTRIES-1:0] row_new_ff, row_new_in;
   logic [CNT_W-1:0] cnt_new_ff, cnt_new_in;
   logic wr_ff, wr_in;

   logic [3:0] r_idx_ff, r_idx_in, r_clr_ff, r_clr_in, r_cnt_ff, r_cnt_in;
   logic r_fg_ff, r_fg_in, r_full_ff, r_full_in;

   logic accept;
   assign csr_ready = 1'b1;
   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff <= 24'd657930;
         min_mod_ff <= '0;
         max_mod_ff <= '0;
         limit_ff <= 16'd1000;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LEARN_BOUNDS: bounds_ff <= csr_wdata[23:0];
            CSR_MIN_MOD_C0: min_mod_ff[0] <= csr_wdata[8:0];
            CSR_MIN_MOD_C1: min_mod_ff[1] <= csr_wdata[8:0];
            CSR_MIN_MOD_C2: min_mod_ff[2] <= csr_wdata[8:0];
            CSR_MAX_MOD_C0: max_mod_ff[0] <= csr_wdata[8:0];
            CSR_MAX_MOD_C1: max_mod_ff[1] <= csr_wdata[8:0];
            CSR_MAX_MOD_C2: max_mod_ff[2] <= csr_wdata[8:0];
            CSR_STALE_LIMIT: limit_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_operation;
         pix_ff <= req_pixel_index[PA_W-1:0];
         in_range_ff <= (32'(req_pixel_index) < 32'(NUM_PIXELS));
         p_ff[0] <= req_channel_0;
         p_ff[1] <= req_channel_1;
         p_ff[2] <= req_channel_2;
         t_ff <= req_frame_time;
      end
   end

   always_ff @(posedge clock) begin
      for (int e = 0; e < MAX_ENTRIES; e++) begin
         row_q[e] <= row_mem[pix_ff][e];
      end
      cnt_q <= cnt_mem[pix_ff];
      if (state_ff == ST_CLEAR) begin
         cnt_mem[sweep_ff] <= '0;
      end else if (wr_ff) begin
         cnt_mem[pix_ff] <= cnt_new_ff;
         for (int e = 0; e < MAX_ENTRIES; e++) begin
            row_mem[pix_ff][e] <= row_new_ff[e];
         end
      end
   end

   always_comb begin
      logic found;
      logic [CNT_W-1:0] hit, k, used;
      logic ok, full;
      logic [CH_MAX-1:0][7:0] hi, lo;
      logic signed [17:0] run;
      logic [9:0] sum;
      logic signed [10:0] lw, hg, pv;
      entry_type en;
      found = 1'b0;
      hit = '0;
      k = '0;
      full = 1'b0;
      ok = 1'b0;
      run = '0;
      lw = '0;
      hg = '0;
      pv = '0;
      en = '0;
      used = (cnt_q > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : cnt_q;
      row_new_in = row_q;
      cnt_new_in = used;
      wr_in = 1'b0;
      r_idx_in = 4'(MAX_ENTRIES);
      r_fg_in = 1'b0;
      r_clr_in = '0;
      r_full_in = 1'b0;
      r_cnt_in = '0;
      for (int n = 0; n < CH_MAX; n++) begin
         sum = 10'(p_ff[n]) + 10'(bounds_ff[8*n +: 8]);
         hi[n] = (sum > 10'd255) ? 8'd255 : sum[7:0];
         lo[n] = (p_ff[n] > bounds_ff[8*n +: 8]) ? (p_ff[n] - bounds_ff[8*n +: 8]) : 8'd0;
      end
      if (in_range_ff) begin
         r_cnt_in = 4'(used);
         case (op_ff)
            OP_LEARN: begin
               wr_in = 1'b1;
               for (int e = 0; e < MAX_ENTRIES; e++) begin
                  ok = (CNT_W'(e) < used);
                  for (int n = 0; n < CHANNELS; n++) begin
                     if (!(row_q[e].learn_lo[n] <= p_ff[n] && p_ff[n] <= row_q[e].learn_hi[n]))
                        ok = 1'b0;
                  end
                  if (ok && !found) begin
                     found = 1'b1;
                     hit = CNT_W'(e);
                  end
               end
               for (int e = 0; e < MAX_ENTRIES; e++) begin
                  en = row_q[e];
                  if (found && hit == CNT_W'(e)) begin
                     en.last_time = t_ff;
                     for (int n = 0; n < CHANNELS; n++) begin
                        if (en.box_max[n] < p_ff[n]) en.box_max[n] = p_ff[n];
                        else if (en.box_min[n] > p_ff[n]) en.box_min[n] = p_ff[n];
                     end
                  end
                  if (CNT_W'(e) < used) begin
                     run = 18'(signed'({1'b0, t_ff})) - 18'(signed'({1'b0, en.last_time}));
                     if (18'(signed'({1'b0, en.stale})) < run) en.stale = run[15:0];
                  end
                  if (!found && CNT_W'(e) == used) begin
                     for (int n = 0; n < CHANNELS; n++) begin
                        en.learn_hi[n] = hi[n];
                        en.learn_lo[n] = lo[n];
                        en.box_max[n] = p_ff[n];
                        en.box_min[n] = p_ff[n];
                     end
                     en.last_time = t_ff;
                     en.stale = '0;
                  end
                  if ((found && hit == CNT_W'(e)) || (!found && CNT_W'(e) == used)) begin
                     for (int n = 0; n < CHANNELS; n++) begin
                        if (en.learn_hi[n] < hi[n]) en.learn_hi[n] = en.learn_hi[n] + 8'd1;
                        if (en.learn_lo[n] > lo[n]) en.learn_lo[n] = en.learn_lo[n] - 8'd1;
                     end
                  end
                  row_new_in[e] = en;
               end
               if (found) begin
                  r_idx_in = 4'(hit);
               end else if (used < CNT_W'(MAX_ENTRIES)) begin
                  r_idx_in = 4'(used);
                  cnt_new_in = used + CNT_W'(1);
                  r_cnt_in = 4'(used + CNT_W'(1));
               end else begin
                  full = 1'b1;
               end
               r_full_in = full;
            end
            OP_CLASSIFY: begin
               r_fg_in = 1'b1;
               for (int e = 0; e < MAX_ENTRIES; e++) begin
                  ok = (CNT_W'(e) < used);
                  for (int n = 0; n < CHANNELS; n++) begin
                     lw = 11'(row_q[e].box_min[n]) - 11'(signed'(min_mod_ff[n]));
                     hg = 11'(row_q[e].box_max[n]) + 11'(signed'(max_mod_ff[n]));
                     pv = signed'(11'(p_ff[n]));
                     if (!(lw <= pv && pv <= hg)) ok = 1'b0;
                  end
                  if (ok) r_fg_in = 1'b0;
               end
            end
            OP_CLEAR: begin
               wr_in = 1'b1;
               for (int e = 0; e < MAX_ENTRIES; e++) begin
                  if (CNT_W'(e) < used) begin
                     if (row_q[e].stale > limit_ff) begin
                        r_clr_in = r_clr_in + 4'd1;
                     end else begin
                        en = row_q[e];
                        en.last_time = '0;
                        for (int d = 0; d < MAX_ENTRIES; d++) begin
                           if (CNT_W'(d) == k) row_new_in[d] = en;
                        end
                        k = k + CNT_W'(1);
                     end
                  end
               end
               cnt_new_in = k;
               r_cnt_in = 4'(k);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      case (state_ff)
         ST_CLEAR: begin
            sweep_in = sweep_ff + PA_W'(1);
            if (32'(sweep_ff) == NUM_PIXELS - 1) state_in = ST_IDLE;
         end
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sweep_ff <= '0;
         wr_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         wr_ff <= (state_ff == ST_EVAL) && wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EVAL) begin
         row_new_ff <= row_new_in;
         cnt_new_ff <= cnt_new_in;
         r_idx_ff <= r_idx_in;
         r_fg_ff <= r_fg_in;
         r_clr_ff <= r_clr_in;
         r_full_ff <= r_full_in;
         r_cnt_ff <= r_cnt_in;
      end
   end

   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_entry_index = r_idx_ff;
   assign rsp_foreground = r_fg_ff;
   assign rsp_cleared_count = r_clr_ff;
   assign rsp_table_full = r_full_ff;
   assign rsp_entry_count = r_cnt_ff;
endmodule
`default_nettype wire

>>> verif/codebook_background_model_core_tb.sv
`default_nettype none
module codebook_background_model_core_tb;
   import cbm_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int PIXELS = 4096;
   localparam int ENTRIES = 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [3:0] entry_index;
      logic       foreground;
      logic [3:0] cleared_count;
      logic       table_full;
      logic [3:0] entry_count;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation = OP_LEARN;
   logic [11:0] req_pixel_index = '0;
   logic [7:0]  req_channel_0 = '0;
   logic [7:0]  req_channel_1 = '0;
   logic [7:0]  req_channel_2 = '0;
   logic [15:0] req_frame_time = '0;
   logic        rsp_valid;
   logic [3:0]  rsp_entry_index;
   logic        rsp_foreground;
   logic [3:0]  rsp_cleared_count;
   logic        rsp_table_full;
   logic [3:0]  rsp_entry_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   codebook_background_model_core dut (.*);

   always #4 clock = ~clock;

   // register mirror
   logic [23:0]       bounds_reg;
   logic signed [8:0] min_mod [3];
   logic signed [8:0] max_mod [3];
   logic [15:0]       stale_limit_reg;

   // codebook mirror
   logic [3:0]  used_count [PIXELS];
   logic [7:0]  learn_hi [PIXELS*ENTRIES][3];
   logic [7:0]  learn_lo [PIXELS*ENTRIES][3];
   logic [7:0]  seen_max [PIXELS*ENTRIES][3];
   logic [7:0]  seen_min [PIXELS*ENTRIES][3];
   logic [15:0] last_time [PIXELS*ENTRIES];
   logic [15:0] stale_cnt [PIXELS*ENTRIES];

   outcome_type pending_q[$];
   int errors = 0;
   int responses = 0;
   int requests = 0;
   int gap_pct = 0;
   int cycles = 0;
   int learns = 0, classifies = 0, clears = 0, fulls = 0;
   logic [15:0] frame_now = 16'd1;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         outcome_type e;
         responses <= responses + 1;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected response idx=%0d", $time, rsp_entry_index);
            errors++;
         end else begin
            e = pending_q.pop_front();
            if (e.entry_index !== rsp_entry_index) begin
               $display("%0t: entry_index exp %0d got %0d", $time, e.entry_index,
                        rsp_entry_index);
               errors++;
            end
            if (e.foreground !== rsp_foreground) begin
               $display("%0t: foreground exp %0d got %0d", $time, e.foreground,
                        rsp_foreground);
               errors++;
            end
            if (e.cleared_count !== rsp_cleared_count) begin
               $display("%0t: cleared_count exp %0d got %0d", $time, e.cleared_count,
                        rsp_cleared_count);
               errors++;
            end
            if (e.table_full !== rsp_table_full) begin
               $display("%0t: table_full exp %0d got %0d", $time, e.table_full,
                        rsp_table_full);
               errors++;
            end
            if (e.entry_count !== rsp_entry_count) begin
               $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count,
                        rsp_entry_count);
               errors++;
            end
         end
      end
   end

   function automatic outcome_type model_codebook(input logic [1:0] op, input logic [11:0] pix,
         input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
         input logic [15:0] ft);
      outcome_type r;
      int p [3];
      int hi [3];
      int lo [3];
      int used, base, i, s, k, n, b, run, e, lim_lo, lim_hi;
      bit ok, found;
      r.entry_index = 4'(ENTRIES);
      r.foreground = 1'b0;
      r.cleared_count = '0;
      r.table_full = 1'b0;
      p[0] = c0; p[1] = c1; p[2] = c2;
      base = int'(pix) * ENTRIES;
      used = used_count[pix];
      if (op == OP_LEARN) begin
         learns++;
         for (n = 0; n < 3; n++) begin
            b = bounds_reg[8*n +: 8];
            hi[n] = (p[n] + b > 255) ? 255 : p[n] + b;
            lo[n] = (p[n] - b < 0) ? 0 : p[n] - b;
         end
         found = 0;
         for (i = 0; i < used && !found; i++) begin
            e = base + i;
            ok = 1;
            for (n = 0; n < 3; n++)
               if (!(learn_lo[e][n] <= p[n] && p[n] <= learn_hi[e][n])) ok = 0;
            if (ok) begin
               found = 1;
               k = i;
               last_time[e] = ft;
               for (n = 0; n < 3; n++) begin
                  if (seen_max[e][n] < p[n]) seen_max[e][n] = 8'(p[n]);
                  else if (seen_min[e][n] > p[n]) seen_min[e][n] = 8'(p[n]);
               end
            end
         end
         for (s = 0; s < used; s++) begin
            run = int'(ft) - int'(last_time[base + s]);
            if (int'(stale_cnt[base + s]) < run) stale_cnt[base + s] = 16'(run);
         end
         if (!found) begin
            k = used;
            if (used < ENTRIES) begin
               e = base + used;
               for (n = 0; n < 3; n++) begin
                  learn_hi[e][n] = 8'(hi[n]);
                  learn_lo[e][n] = 8'(lo[n]);
                  seen_max[e][n] = 8'(p[n]);
                  seen_min[e][n] = 8'(p[n]);
               end
               last_time[e] = ft;
               stale_cnt[e] = '0;
               used++;
            end else begin
               r.table_full = 1'b1;
               fulls++;
            end
         end
         if (!r.table_full) begin
            e = base + k;
            for (n = 0; n < 3; n++) begin
               if (learn_hi[e][n] < hi[n]) learn_hi[e][n]++;
               if (learn_lo[e][n] > lo[n]) learn_lo[e][n]--;
            end
            r.entry_index = 4'(k);
         end
      end else if (op == OP_CLASSIFY) begin
         classifies++;
         r.foreground = 1'b1;
         for (i = 0; i < used && r.foreground; i++) begin
            e = base + i;
            ok = 1;
            for (n = 0; n < 3; n++) begin
               lim_lo = int'(seen_min[e][n]) - int'(min_mod[n]);
               lim_hi = int'(seen_max[e][n]) + int'(max_mod[n]);
               if (!(lim_lo <= p[n] && p[n] <= lim_hi)) ok = 0;
            end
            if (ok) r.foreground = 1'b0;
         end
      end else if (op == OP_CLEAR) begin
         clears++;
         k = 0;
         for (i = 0; i < used; i++) begin
            e = base + i;
            if (stale_cnt[e] > stale_limit_reg) begin
               r.cleared_count++;
            end else begin
               if (k != i) begin
                  learn_hi[base + k] = learn_hi[e];
                  learn_lo[base + k] = learn_lo[e];
                  seen_max[base + k] = seen_max[e];
                  seen_min[base + k] = seen_min[e];
                  stale_cnt[base + k] = stale_cnt[e];
               end
               last_time[base + k] = '0;
               k++;
            end
         end
         used = k;
      end
      used_count[pix] = 4'(used);
      r.entry_count = 4'(used);
      return r;
   endfunction

   task automatic send_request(input logic [1:0] op, input logic [11:0] pix,
         input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
         input logic [15:0] ft);
      while ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_pixel_index <= pix;
      req_channel_0 <= c0;
      req_channel_1 <= c1;
      req_channel_2 <= c2;
      req_frame_time <= ft;
      do @(posedge clock); while (busy);
      pending_q.push_back(model_codebook(op, pix, c0, c1, c2, ft));
      requests++;
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LEARN_BOUNDS: bounds_reg = data[23:0];
         CSR_MIN_MOD_C0: min_mod[0] = data[8:0];
         CSR_MIN_MOD_C1: min_mod[1] = data[8:0];
         CSR_MIN_MOD_C2: min_mod[2] = data[8:0];
         CSR_MAX_MOD_C0: max_mod[0] = data[8:0];
         CSR_MAX_MOD_C1: max_mod[1] = data[8:0];
         CSR_MAX_MOD_C2: max_mod[2] = data[8:0];
         default: stale_limit_reg = data[15:0];
      endcase
   endtask

   task automatic write_mods(input int lo_mod, input int hi_mod);
      write_csr(CSR_MIN_MOD_C0, 32'(lo_mod) & 32'h1FF);
      write_csr(CSR_MIN_MOD_C1, 32'(lo_mod) & 32'h1FF);
      write_csr(CSR_MIN_MOD_C2, 32'(lo_mod) & 32'h1FF);
      write_csr(CSR_MAX_MOD_C0, 32'(hi_mod) & 32'h1FF);
      write_csr(CSR_MAX_MOD_C1, 32'(hi_mod) & 32'h1FF);
      write_csr(CSR_MAX_MOD_C2, 32'(hi_mod) & 32'h1FF);
   endtask

   task automatic test_basic_ops;
      send_request(OP_CLASSIFY, 12'd5, 8'd10, 8'd10, 8'd10, 16'd0);
      send_request(OP_LEARN, 12'd5, 8'd0, 8'd0, 8'd0, 16'd0);
      send_request(OP_LEARN, 12'd5, 8'd255, 8'd255, 8'd255, 16'hFFFF);
      send_request(OP_LEARN, 12'd5, 8'd3, 8'd4, 8'd5, 16'd100);
      send_request(OP_CLASSIFY, 12'd5, 8'd2, 8'd2, 8'd2, 16'd0);
      send_request(OP_CLASSIFY, 12'd5, 8'd128, 8'd128, 8'd128, 16'd0);
      send_request(OP_NONE, 12'd5, 8'd1, 8'd2, 8'd3, 16'd7);
      send_request(OP_LEARN, 12'hFFF, 8'd170, 8'd85, 8'd170, 16'h5555);
      send_request(OP_LEARN, 12'hFFF, 8'd170, 8'd85, 8'd170, 16'h0010);
      send_request(OP_CLEAR, 12'd5, 8'd0, 8'd0, 8'd0, 16'd0);
      send_request(OP_CLEAR, 12'hFFF, 8'd0, 8'd0, 8'd0, 16'd0);
   endtask

   task automatic test_full_codebook;
      drain();
      write_csr(CSR_LEARN_BOUNDS, 32'h000000);
      for (int i = 0; i < 10; i++)
         send_request(OP_LEARN, 12'd9, 8'(i * 25), 8'(255 - i * 25), 8'(i), 16'(i * 3));
      send_request(OP_CLASSIFY, 12'd9, 8'd50, 8'd205, 8'd2, 16'd0);
      drain();
      write_csr(CSR_STALE_LIMIT, 32'd0);
      send_request(OP_CLEAR, 12'd9, 8'd0, 8'd0, 8'd0, 16'd0);
   endtask

   task automatic test_mod_extremes;
      drain();
      write_csr(CSR_LEARN_BOUNDS, 32'hFFFFFF);
      write_mods(-255, -255);
      send_request(OP_LEARN, 12'd20, 8'd100, 8'd100, 8'd100, 16'd1);
      send_request(OP_CLASSIFY, 12'd20, 8'd100, 8'd100, 8'd100, 16'd0);
      drain();
      write_mods(255, 255);
      send_request(OP_CLASSIFY, 12'd20, 8'd0, 8'd255, 8'd7, 16'd0);
      drain();
      write_csr(CSR_STALE_LIMIT, 32'hFFFF);
      send_request(OP_CLEAR, 12'd20, 8'd0, 8'd0, 8'd0, 16'd0);
   endtask

   task automatic test_random(input int pct, input int count);
      logic [1:0] op;
      logic [11:0] pix;
      logic [7:0] c [3];
      int r, v;
      drain();
      gap_pct = pct;
      write_csr(CSR_LEARN_BOUNDS, 32'({8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)),
                                       8'($urandom_range(0, 20))}));
      write_mods($urandom_range(0, 30) - 10, $urandom_range(0, 30) - 10);
      write_csr(CSR_STALE_LIMIT, 32'($urandom_range(0, 200)));
      for (int j = 0; j < count; j++) begin
         r = $urandom_range(0, 99);
         op = (r < 60) ? OP_LEARN : (r < 90) ? OP_CLASSIFY : (r < 97) ? OP_CLEAR : OP_NONE;
         pix = ($urandom_range(0, 99) < 85) ? 12'($urandom_range(0, 15)) : 12'($urandom);
         for (int n = 0; n < 3; n++) begin
            if ($urandom_range(0, 99) < 20) c[n] = 8'($urandom);
            else begin
               v = (int'(pix[1:0]) + n) * 60 + $urandom_range(0, 30) - 15;
               c[n] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
            end
         end
         if ($urandom_range(0, 99) < 5) frame_now = 16'($urandom);
         else frame_now = frame_now + 16'($urandom_range(0, 30));
         send_request(op, pix, c[0], c[1], c[2], frame_now);
      end
   endtask

   initial begin
      bounds_reg = 24'd657930;
      for (int n = 0; n < 3; n++) begin
         min_mod[n] = '0;
         max_mod[n] = '0;
      end
      stale_limit_reg = 16'd1000;
      for (int i = 0; i < PIXELS; i++) used_count[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_full_codebook();
      test_mod_extremes();
      test_random(34, 450);
      test_random(62, 450);
      test_random(0, 450);
      drain();
      $display("covered %0d requests, %0d responses checked", requests, responses);
      $display("learn %0d (full %0d), classify %0d, clear %0d", learns, fulls,
               classifies, clears);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
hdl/cbm_pkg.sv
hdl/codebook_background_model_core.sv
verif/codebook_background_model_core_tb.sv
